[design/opd_pkg.sv]
// Shared types, codes and constants of the pack deframer.
`default_nettype none

package opd_pkg;

	localparam int HEADER_LEN  = 16;
	localparam int MAGIC_LEN   = 8;
	localparam int VERSION_END = 12;
	localparam int SIZE_LEN    = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] VERSION_RESET = 32'd1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TYPE,
		PH_HLEN,
		PH_HASH,
		PH_SIZE,
		PH_DATA,
		PH_TRAIL,
		PH_DISCARD
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER,
		KIND_TYPE,
		KIND_HASH_LEN,
		KIND_HASH,
		KIND_SIZE,
		KIND_DATA,
		KIND_TRAILING,
		KIND_DISCARDED
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_SMALL,
		ST_BAD_MAGIC,
		ST_BAD_VERSION,
		ST_TRUNC_PACK,
		ST_TRUNC_HASH,
		ST_TRUNC_SIZE,
		ST_TRUNC_DATA
	} status_t;

	// One word as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       zero;
	} word_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] pos);
		logic [7:0] m;
		unique case (pos)
			3'd0: m = 8'h44;
			3'd1: m = 8'h4E;
			3'd2: m = 8'h59;
			3'd3: m = 8'h50;
			3'd4: m = 8'h41;
			3'd5: m = 8'h43;
			3'd6: m = 8'h4B;
			3'd7: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[design/opd_front.sv]
// Front stage: takes input words, flags zero bytes and feeds the queue.
`default_nettype none

module opd_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [7:0]        data_byte,
	input  wire               end_of_pack,
	input  wire               q_full,
	output logic              push,
	output opd_pkg::word_t    push_word
);

	logic           s1_valid_q;
	opd_pkg::word_t word_s1;

	// hold the word while the queue is full
	assign in_stall  = s1_valid_q && q_full;
	assign push      = s1_valid_q && !q_full;
	assign push_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1.value <= data_byte;
			word_s1.last  <= end_of_pack;
			word_s1.zero  <= (data_byte == 8'd0);
		end
	end

endmodule

`default_nettype wire

[design/opd_queue.sv]
// Short word queue between the front and the back.
`default_nettype none

module opd_queue #(
	parameter int DEPTH = opd_pkg::QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  opd_pkg::word_t    push_word,
	output logic              full,
	input  wire               pop,
	output logic              nonempty,
	output opd_pkg::word_t    pop_word
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	opd_pkg::word_t     slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_word = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= advance(wr_ptr_q);
			if (do_pop) rd_ptr_q <= advance(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_word;
	end

endmodule

`default_nettype wire

[design/opd_back.sv]
// Back stage: pack parser state machine and result register.
`default_nettype none

module opd_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [31:0]       expected_version,
	input  wire               q_nonempty,
	input  opd_pkg::word_t    q_word,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [2:0]        byte_kind,
	output logic [7:0]        byte_value,
	output logic [31:0]       entry_number,
	output logic              field_end,
	output logic [2:0]        status,
	output logic              outcome_final
);

	opd_pkg::phase_t  phase_q, phase_n;
	logic [3:0]       hpos_q, hpos_n;
	logic             magic_bad_q, magic_bad_n;
	logic [31:0]      version_q, version_n;
	logic [31:0]      count_q, count_n;
	logic             count_nz_q, count_nz_n;
	logic [31:0]      done_q, done_n;
	logic [7:0]       hash_rem_q, hash_rem_n;
	logic [63:0]      size_q, size_n;
	logic             size_nz_q, size_nz_n;
	logic [63:0]      data_rem_q, data_rem_n;
	logic [2:0]       size_cnt_q, size_cnt_n;
	opd_pkg::status_t held_q, held_n;

	opd_pkg::kind_t   kind;
	opd_pkg::status_t st;
	opd_pkg::status_t err_code;
	logic             err, ok, entry_fin, fend, fin;
	logic             out_valid_q;

	// take a word whenever the result register is free or being emptied
	assign pop       = q_nonempty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		phase_n     = phase_q;
		hpos_n      = hpos_q;
		magic_bad_n = magic_bad_q;
		version_n   = version_q;
		count_n     = count_q;
		count_nz_n  = count_nz_q;
		done_n      = done_q;
		hash_rem_n  = hash_rem_q;
		size_n      = size_q;
		size_nz_n   = size_nz_q;
		data_rem_n  = data_rem_q;
		size_cnt_n  = size_cnt_q;
		held_n      = held_q;
		kind        = opd_pkg::KIND_DISCARDED;
		st          = opd_pkg::ST_OK;
		err_code    = opd_pkg::ST_OK;
		err         = 1'b0;
		ok          = 1'b0;
		entry_fin   = 1'b0;
		fend        = 1'b0;
		fin         = 1'b0;

		unique case (phase_q)
			opd_pkg::PH_HEADER: begin
				kind   = opd_pkg::KIND_HEADER;
				hpos_n = hpos_q + 4'd1;
				if (hpos_q < 4'(opd_pkg::MAGIC_LEN)) begin
					if (q_word.value != opd_pkg::magic_byte(hpos_q[2:0])) magic_bad_n = 1'b1;
				end else if (hpos_q < 4'(opd_pkg::VERSION_END)) begin
					version_n = {version_q[23:0], q_word.value};
				end else begin
					count_n    = {count_q[23:0], q_word.value};
					count_nz_n = count_nz_q || !q_word.zero;
				end
				// bad magic outranks bad version; a zero count ends the pack here
				if (hpos_q == 4'(opd_pkg::HEADER_LEN - 1)) begin
					if (magic_bad_q) begin
						err = 1'b1; err_code = opd_pkg::ST_BAD_MAGIC;
					end else if (version_q != expected_version) begin
						err = 1'b1; err_code = opd_pkg::ST_BAD_VERSION;
					end else if (!count_nz_n) begin
						ok = 1'b1;
					end else if (q_word.last) begin
						err = 1'b1; err_code = opd_pkg::ST_TRUNC_PACK;
					end else begin
						phase_n = opd_pkg::PH_TYPE;
					end
				end else if (q_word.last) begin
					err = 1'b1; err_code = opd_pkg::ST_TOO_SMALL;
				end
			end
			opd_pkg::PH_TYPE: begin
				kind = opd_pkg::KIND_TYPE;
				if (q_word.last) begin
					err = 1'b1; err_code = opd_pkg::ST_TRUNC_HASH;
				end else begin
					phase_n = opd_pkg::PH_HLEN;
				end
			end
			opd_pkg::PH_HLEN: begin
				kind       = opd_pkg::KIND_HASH_LEN;
				hash_rem_n = q_word.value;
				size_n     = '0;
				size_nz_n  = 1'b0;
				size_cnt_n = '0;
				if (q_word.zero) begin
					if (q_word.last) begin
						err = 1'b1; err_code = opd_pkg::ST_TRUNC_SIZE;
					end else begin
						phase_n = opd_pkg::PH_SIZE;
					end
				end else if (q_word.last) begin
					err = 1'b1; err_code = opd_pkg::ST_TRUNC_HASH;
				end else begin
					phase_n = opd_pkg::PH_HASH;
				end
			end
			opd_pkg::PH_HASH: begin
				kind       = opd_pkg::KIND_HASH;
				hash_rem_n = hash_rem_q - 8'd1;
				if (hash_rem_q == 8'd1) begin
					fend = 1'b1;
					if (q_word.last) begin
						err = 1'b1; err_code = opd_pkg::ST_TRUNC_SIZE;
					end else begin
						phase_n = opd_pkg::PH_SIZE;
					end
				end else if (q_word.last) begin
					err = 1'b1; err_code = opd_pkg::ST_TRUNC_HASH;
				end
			end
			opd_pkg::PH_SIZE: begin
				kind       = opd_pkg::KIND_SIZE;
				size_n     = {size_q[55:0], q_word.value};
				size_nz_n  = size_nz_q || !q_word.zero;
				size_cnt_n = size_cnt_q + 3'd1;
				if (size_cnt_q == 3'(opd_pkg::SIZE_LEN - 1)) begin
					fend       = 1'b1;
					data_rem_n = size_n;
					if (!size_nz_n) begin
						entry_fin = 1'b1;
					end else if (q_word.last) begin
						err = 1'b1; err_code = opd_pkg::ST_TRUNC_DATA;
					end else begin
						phase_n = opd_pkg::PH_DATA;
					end
				end else if (q_word.last) begin
					err = 1'b1; err_code = opd_pkg::ST_TRUNC_SIZE;
				end
			end
			opd_pkg::PH_DATA: begin
				kind       = opd_pkg::KIND_DATA;
				data_rem_n = data_rem_q - 64'd1;
				if (data_rem_q == 64'd1) begin
					fend      = 1'b1;
					entry_fin = 1'b1;
				end else if (q_word.last) begin
					err = 1'b1; err_code = opd_pkg::ST_TRUNC_DATA;
				end
			end
			opd_pkg::PH_TRAIL: begin
				kind = opd_pkg::KIND_TRAILING;
				st   = held_q;
			end
			opd_pkg::PH_DISCARD: begin
				kind = opd_pkg::KIND_DISCARDED;
				st   = held_q;
			end
		endcase

		if (entry_fin) begin
			done_n = done_q + 32'd1;
			if (done_n == count_q) begin
				ok = 1'b1;
			end else if (q_word.last) begin
				err = 1'b1; err_code = opd_pkg::ST_TRUNC_PACK;
			end else begin
				phase_n = opd_pkg::PH_TYPE;
			end
		end

		if (err) begin
			held_n  = err_code;
			st      = err_code;
			fin     = 1'b1;
			phase_n = opd_pkg::PH_DISCARD;
		end else if (ok) begin
			held_n  = opd_pkg::ST_OK;
			st      = opd_pkg::ST_OK;
			fin     = 1'b1;
			phase_n = opd_pkg::PH_TRAIL;
		end

		// drop all parse state at the end of the buffer
		if (q_word.last) begin
			phase_n     = opd_pkg::PH_HEADER;
			hpos_n      = '0;
			magic_bad_n = 1'b0;
			version_n   = '0;
			count_n     = '0;
			count_nz_n  = 1'b0;
			done_n      = '0;
			hash_rem_n  = '0;
			size_n      = '0;
			size_nz_n   = 1'b0;
			data_rem_n  = '0;
			size_cnt_n  = '0;
			held_n      = opd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= opd_pkg::PH_HEADER;
			hpos_q      <= '0;
			magic_bad_q <= 1'b0;
			version_q   <= '0;
			count_q     <= '0;
			count_nz_q  <= 1'b0;
			done_q      <= '0;
			hash_rem_q  <= '0;
			size_q      <= '0;
			size_nz_q   <= 1'b0;
			data_rem_q  <= '0;
			size_cnt_q  <= '0;
			held_q      <= opd_pkg::ST_OK;
		end else if (pop) begin
			phase_q     <= phase_n;
			hpos_q      <= hpos_n;
			magic_bad_q <= magic_bad_n;
			version_q   <= version_n;
			count_q     <= count_n;
			count_nz_q  <= count_nz_n;
			done_q      <= done_n;
			hash_rem_q  <= hash_rem_n;
			size_q      <= size_n;
			size_nz_q   <= size_nz_n;
			data_rem_q  <= data_rem_n;
			size_cnt_q  <= size_cnt_n;
			held_q      <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_kind     <= kind;
			byte_value    <= q_word.value;
			entry_number  <= done_q;
			field_end     <= fend;
			status        <= st;
			outcome_final <= fin;
		end
	end

`ifndef SYNTH
	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && outcome_final |->
			byte_kind != opd_pkg::KIND_TRAILING && byte_kind != opd_pkg::KIND_DISCARDED)
		else $error("outcome settled on a trailing or discarded word");

	a_fend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && field_end |->
			byte_kind == opd_pkg::KIND_HASH || byte_kind == opd_pkg::KIND_SIZE ||
			byte_kind == opd_pkg::KIND_DATA)
		else $error("field end on a word outside hash, size or data");

	a_trail_ok: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == opd_pkg::PH_TRAIL |-> held_q == opd_pkg::ST_OK)
		else $error("trailing phase with an error held");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_word.last |=> phase_q == opd_pkg::PH_HEADER && hpos_q == 4'd0)
		else $error("parse state not cleared after the last word");
`endif

endmodule

`default_nettype wire

[design/object_pack_deframer.sv]
// Pack deframer top level: configuration register, front, queue and back.
// A word passes through the front register, a queue slot and the back result register.
// Throughput: one word per cycle while out_stall is low; the per-byte parse state loop in the back sets it.
// Reset: arst_n clears all parse and handshake state at once; expected_version returns to 1.
// No clearing pass: the block takes words from the first cycle after reset.
`default_nettype none

module object_pack_deframer #(
	parameter int QUEUE_DEPTH = opd_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         end_of_pack,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  byte_kind,
	output logic [7:0]  byte_value,
	output logic [31:0] entry_number,
	output logic        field_end,
	output logic [2:0]  status,
	output logic        outcome_final
);

	logic [31:0]    expected_version_q;
	logic           reg_hit;
	logic           q_full;
	logic           q_push;
	logic           q_nonempty;
	logic           q_pop;
	opd_pkg::word_t push_word;
	opd_pkg::word_t pop_word;

	assign pready  = 1'b1;
	assign reg_hit = (paddr == 2'd0);
	assign prdata  = reg_hit ? expected_version_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= opd_pkg::VERSION_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			expected_version_q <= pwdata;
		end
	end

	opd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_pack (end_of_pack),
		.q_full      (q_full),
		.push        (q_push),
		.push_word   (push_word)
	);

	opd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_word  (pop_word)
	);

	opd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.expected_version (expected_version_q),
		.q_nonempty       (q_nonempty),
		.q_word           (pop_word),
		.pop              (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.byte_kind        (byte_kind),
		.byte_value       (byte_value),
		.entry_number     (entry_number),
		.field_end        (field_end),
		.status           (status),
		.outcome_final    (outcome_final)
	);

endmodule

`default_nettype wire

[verif/tb_object_pack_deframer.sv]
// Self-checking testbench of the pack deframer: directed packs, then random packs.
`default_nettype none

module tb_object_pack_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  ADDR_VERSION = 2'd0;
	localparam logic [63:0] MAGIC_WORD   = 64'h444E_5950_4143_4B00;
	localparam int          IDLE_LIMIT   = 1000;
	localparam int          DRAIN_CYCLES = 4;

	typedef struct packed {
		opd_pkg::kind_t   kind;
		logic [7:0]       value;
		logic [31:0]      entry;
		logic             fend;
		opd_pkg::status_t st;
		logic             fin;
	} label_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        end_of_pack = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  byte_kind;
	logic [7:0]  byte_value;
	logic [31:0] entry_number;
	logic        field_end;
	logic [2:0]  status;
	logic        outcome_final;

	// predictor state
	logic [31:0]      version_reg;
	opd_pkg::phase_t  ph;
	logic [3:0]       hdr_pos;
	logic             magic_bad;
	logic [31:0]      ver_acc;
	logic [31:0]      n_entries;
	logic [31:0]      n_done;
	logic [7:0]       hash_left;
	logic [63:0]      size_acc;
	logic [63:0]      data_left;
	logic [3:0]       size_cnt;
	opd_pkg::status_t held;

	label_t     labels_due[$];
	logic [7:0] pack_bytes[$];
	int         mismatches = 0;
	int         bytes_sent = 0;
	int         idle_cycles = 0;
	bit         calm = 1'b0;
	int         mode_left = 0;
	int         stall_left = 0;

	object_pack_deframer uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_pack(end_of_pack),
		.out_valid(out_valid), .out_stall(out_stall),
		.byte_kind(byte_kind), .byte_value(byte_value), .entry_number(entry_number),
		.field_end(field_end), .status(status), .outcome_final(outcome_final)
	);

	always #5 clk = ~clk;

	function automatic void restart_parse();
		ph        = opd_pkg::PH_HEADER;
		hdr_pos   = '0;
		magic_bad = 1'b0;
		ver_acc   = '0;
		n_entries = '0;
		n_done    = '0;
		hash_left = '0;
		size_acc  = '0;
		data_left = '0;
		size_cnt  = '0;
		held      = opd_pkg::ST_OK;
	endfunction

	function automatic label_t label_byte(input logic [7:0] b, input logic last);
		label_t           r;
		int               pos;
		opd_pkg::status_t err;
		logic             ok;
		logic             finished;
		r.kind   = opd_pkg::KIND_DISCARDED;
		r.value  = b;
		r.entry  = n_done;
		r.fend   = 1'b0;
		r.st     = opd_pkg::ST_OK;
		r.fin    = 1'b0;
		err      = opd_pkg::ST_OK;
		ok       = 1'b0;
		finished = 1'b0;
		unique case (ph)
			opd_pkg::PH_HEADER: begin
				pos    = int'(hdr_pos);
				r.kind = opd_pkg::KIND_HEADER;
				if (pos < opd_pkg::MAGIC_LEN) begin
					if (b != MAGIC_WORD[63 - 8*pos -: 8])
						magic_bad = 1'b1;
				end else if (pos < opd_pkg::VERSION_END) begin
					ver_acc = {ver_acc[23:0], b};
				end else begin
					n_entries = {n_entries[23:0], b};
				end
				hdr_pos = hdr_pos + 4'd1;
				if (pos == opd_pkg::HEADER_LEN - 1) begin
					// magic outranks version
					if (magic_bad)                    err = opd_pkg::ST_BAD_MAGIC;
					else if (ver_acc != version_reg)  err = opd_pkg::ST_BAD_VERSION;
					else if (n_entries == 32'd0)      ok = 1'b1;
					else if (last)                    err = opd_pkg::ST_TRUNC_PACK;
					else                              ph = opd_pkg::PH_TYPE;
				end else if (last) begin
					err = opd_pkg::ST_TOO_SMALL;
				end
			end
			opd_pkg::PH_TYPE: begin
				r.kind = opd_pkg::KIND_TYPE;
				if (last) err = opd_pkg::ST_TRUNC_HASH;
				else      ph = opd_pkg::PH_HLEN;
			end
			opd_pkg::PH_HLEN: begin
				r.kind    = opd_pkg::KIND_HASH_LEN;
				hash_left = b;
				size_acc  = '0;
				size_cnt  = '0;
				if (b == 8'd0) begin
					if (last) err = opd_pkg::ST_TRUNC_SIZE;
					else      ph = opd_pkg::PH_SIZE;
				end else begin
					if (last) err = opd_pkg::ST_TRUNC_HASH;
					else      ph = opd_pkg::PH_HASH;
				end
			end
			opd_pkg::PH_HASH: begin
				r.kind    = opd_pkg::KIND_HASH;
				hash_left = hash_left - 8'd1;
				if (hash_left == 8'd0) begin
					r.fend = 1'b1;
					if (last) err = opd_pkg::ST_TRUNC_SIZE;
					else      ph = opd_pkg::PH_SIZE;
				end else if (last) begin
					err = opd_pkg::ST_TRUNC_HASH;
				end
			end
			opd_pkg::PH_SIZE: begin
				r.kind   = opd_pkg::KIND_SIZE;
				size_acc = {size_acc[55:0], b};
				size_cnt = size_cnt + 4'd1;
				if (size_cnt >= 4'(opd_pkg::SIZE_LEN)) begin
					r.fend    = 1'b1;
					data_left = size_acc;
					if (data_left == 64'd0) finished = 1'b1;
					else if (last)          err = opd_pkg::ST_TRUNC_DATA;
					else                    ph = opd_pkg::PH_DATA;
				end else if (last) begin
					err = opd_pkg::ST_TRUNC_SIZE;
				end
			end
			opd_pkg::PH_DATA: begin
				r.kind    = opd_pkg::KIND_DATA;
				data_left = data_left - 64'd1;
				if (data_left == 64'd0) begin
					r.fend   = 1'b1;
					finished = 1'b1;
				end else if (last) begin
					err = opd_pkg::ST_TRUNC_DATA;
				end
			end
			opd_pkg::PH_TRAIL: begin
				r.kind = opd_pkg::KIND_TRAILING;
				r.st   = held;
			end
			default: begin
				r.kind = opd_pkg::KIND_DISCARDED;
				r.st   = held;
			end
		endcase

		if (finished) begin
			n_done = n_done + 32'd1;
			if (n_done == n_entries) ok = 1'b1;
			else if (last)           err = opd_pkg::ST_TRUNC_PACK;
			else                     ph = opd_pkg::PH_TYPE;
		end

		if (err != opd_pkg::ST_OK) begin
			held  = err;
			r.st  = err;
			r.fin = 1'b1;
			ph    = opd_pkg::PH_DISCARD;
		end else if (ok) begin
			held  = opd_pkg::ST_OK;
			r.st  = opd_pkg::ST_OK;
			r.fin = 1'b1;
			ph    = opd_pkg::PH_TRAIL;
		end

		if (last)
			restart_parse();
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// compare results first, then log the word taken at this edge
	always @(posedge clk) begin : scoreboard
		label_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (labels_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, got value %0h", $time,
						byte_value);
				end else begin
					e = labels_due.pop_front();
					check_field("byte_kind", 32'(e.kind), 32'(byte_kind));
					check_field("byte_value", 32'(e.value), 32'(byte_value));
					check_field("entry_number", e.entry, entry_number);
					check_field("field_end", 32'(e.fend), 32'(field_end));
					check_field("status", 32'(e.st), 32'(status));
					check_field("outcome_final", 32'(e.fin), 32'(outcome_final));
				end
			end
			if (in_valid && !in_stall)
				labels_due.insert(labels_due.size(), label_byte(data_byte, end_of_pack));
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_object_pack_deframer: done, errors");
				$finish;
			end
		end
	end

	// receiver stalls; calm stretches switch idling off on both sides
	always @(posedge clk) begin : stall_gen
		int r;
		if (mode_left == 0) begin
			calm      <= ($urandom_range(0, 3) == 0);
			mode_left <= $urandom_range(50, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else if (r < 96) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(8, 40);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 93)         return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void append_byte(input logic [7:0] b);
		pack_bytes.insert(pack_bytes.size(), b);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_pack <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic ship(input int cut);
		for (int i = 0; i < cut; i++)
			send_byte(pack_bytes[i], i == cut - 1);
	endtask

	// drop valid and let every outstanding word drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (labels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_version(input logic [31:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_VERSION;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		version_reg = v;
	endtask

	task automatic begin_pack(input logic [31:0] ver, input logic [31:0] count,
			input bit bad_magic);
		int         spoil;
		logic [7:0] flip;
		spoil = bad_magic ? $urandom_range(0, opd_pkg::MAGIC_LEN - 1) : -1;
		flip  = 8'($urandom_range(1, 255));
		pack_bytes.delete();
		for (int i = 0; i < opd_pkg::MAGIC_LEN; i++)
			append_byte(MAGIC_WORD[63 - 8*i -: 8] ^ ((i == spoil) ? flip : 8'h00));
		for (int i = 3; i >= 0; i--)
			append_byte(ver[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			append_byte(count[8*i +: 8]);
	endtask

	task automatic add_entry(input logic [7:0] hlen, input logic [63:0] dsize, input int n_data);
		append_byte(8'($urandom_range(0, 255)));
		append_byte(hlen);
		for (int i = 0; i < hlen; i++)
			append_byte(8'($urandom_range(0, 255)));
		for (int i = 7; i >= 0; i--)
			append_byte(dsize[8*i +: 8]);
		for (int i = 0; i < n_data; i++)
			append_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_tail(input int n);
		for (int i = 0; i < n; i++)
			append_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_header_cases();
		// empty pack settles on its last header byte
		begin_pack(version_reg, 32'd0, 1'b0);
		ship(opd_pkg::HEADER_LEN);
		// short buffer, then short buffer with a spoilt magic
		begin_pack(version_reg, 32'd2, 1'b0);
		ship(5);
		begin_pack(version_reg, 32'd2, 1'b1);
		ship(11);
		// bad magic outranks bad version; the rest is discarded
		begin_pack(~version_reg, 32'd2, 1'b1);
		add_tail(2);
		ship(pack_bytes.size());
		begin_pack(version_reg ^ 32'd1, 32'd0, 1'b0);
		ship(opd_pkg::HEADER_LEN);
		// header ends the buffer with entries still owed
		begin_pack(version_reg, 32'd1, 1'b0);
		ship(opd_pkg::HEADER_LEN);
	endtask

	task automatic test_entry_truncation();
		int cuts[8] = '{17, 18, 19, 21, 24, 29, 31, 33};
		for (int i = 0; i < 8; i++) begin
			begin_pack(version_reg, (i == 7) ? 32'd2 : 32'd1, 1'b0);
			add_entry(8'd3, 64'd4, 4);
			ship(cuts[i]);
		end
		// zero hash length at the end of the buffer
		begin_pack(version_reg, 32'd1, 1'b0);
		add_entry(8'd0, 64'd4, 4);
		ship(18);
		// zero-size entry completes on the final byte with entries left
		begin_pack(version_reg, 32'd2, 1'b0);
		add_entry(8'd0, 64'd0, 0);
		ship(pack_bytes.size());
		// size far beyond 32 bits, cut inside the data
		begin_pack(version_reg, 32'd1, 1'b0);
		add_entry(8'd1, 64'hFF00_0000_0000_0003, 6);
		ship(pack_bytes.size());
		begin_pack(version_reg, 32'hFFFF_FFFF, 1'b0);
		add_entry(8'd0, 64'd1, 1);
		add_entry(8'd2, 64'd0, 0);
		ship(pack_bytes.size());
	endtask

	task automatic test_full_packs();
		begin_pack(version_reg, 32'd2, 1'b0);
		add_entry(8'd6, 64'd0, 0);
		add_entry(8'd2, 64'd5, 5);
		add_tail(3);
		ship(pack_bytes.size());
		// success on the final byte of a zero-size entry
		begin_pack(version_reg, 32'd1, 1'b0);
		add_entry(8'd1, 64'd0, 0);
		ship(pack_bytes.size());
	endtask

	task automatic test_version_register();
		logic [31:0] settings[3] = '{32'h0000_0000, 32'hFFFF_FFFF, opd_pkg::VERSION_RESET};
		for (int i = 0; i < 3; i++) begin
			wait_idle();
			write_version(settings[i]);
			begin_pack(settings[i], 32'd0, 1'b0);
			ship(opd_pkg::HEADER_LEN);
			begin_pack(settings[i] ^ 32'h8000_0001, 32'd0, 1'b0);
			ship(opd_pkg::HEADER_LEN);
		end
	endtask

	task automatic test_random_packs(input int n_bytes);
		int       target;
		int       mode;
		int       cnt;
		int       hlen;
		int       dsize;
		int       len;
		bit       coin;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			mode = $urandom_range(0, 9);
			if (mode == 9) begin
				// noise
				pack_bytes.delete();
				len = $urandom_range(1, 24);
				add_tail(len);
				ship(len);
			end else begin
				coin = $urandom_range(0, 1);
				cnt  = $urandom_range(0, 3);
				begin_pack((mode == 8 && coin) ? $urandom : version_reg,
					($urandom_range(0, 9) == 0) ? 32'(cnt + 1) : 32'(cnt),
					mode == 8 && !coin);
				for (int i = 0; i < cnt; i++) begin
					hlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
						: $urandom_range(0, 4);
					dsize = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
						: $urandom_range(0, 4);
					add_entry(8'(hlen), 64'(dsize), dsize);
				end
				if ($urandom_range(0, 2) == 0)
					add_tail($urandom_range(1, 3));
				ship((mode == 7) ? $urandom_range(1, pack_bytes.size()) : pack_bytes.size());
			end
		end
	endtask

	initial begin
		version_reg = opd_pkg::VERSION_RESET;
		restart_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_cases();
		test_entry_truncation();
		test_full_packs();
		test_version_register();
		for (int p = 0; p < 2; p++) begin
			wait_idle();
			write_version((p == 1) ? opd_pkg::VERSION_RESET : $urandom);
			test_random_packs(10);
		end
		wait_idle();

		if (mismatches == 0)
			$display("tb_object_pack_deframer: done, clean");
		else
			$display("tb_object_pack_deframer: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
